FILE: rtl/stbc_pkg.sv
`timescale 1ns / 1ps

package stbc_pkg;

  // Code modes held in the configuration register
  typedef enum logic [1:0] {
    MODE_ALAMOUTI      = 2'd0,
    MODE_ALAMOUTI_SWAP = 2'd1,
    MODE_OSTBC3        = 2'd2,
    MODE_OSTBC4        = 2'd3
  } code_mode_t;

  localparam int NUM_ANT   = 4;
  localparam int NUM_SLOTS = 4;  // samples in the largest code block
  localparam int BUF_DEPTH = 3;  // the completing sample bypasses the buffer

  // Last row of a code block for each antenna family
  localparam logic [2:0] ROW_LAST_2ANT = 3'd1;
  localparam logic [2:0] ROW_LAST_4ANT = 3'd7;

  // Rows 0..3 of the four-antenna code: sample slot and negation per antenna.
  // The Alamouti modes use rows 0 and 1 of the same table.
  localparam logic [1:0] ROW_IDX [NUM_SLOTS][NUM_ANT] = '{
    '{2'd0, 2'd1, 2'd2, 2'd3},
    '{2'd1, 2'd0, 2'd3, 2'd2},
    '{2'd2, 2'd3, 2'd0, 2'd1},
    '{2'd3, 2'd2, 2'd1, 2'd0}
  };

  localparam logic ROW_NEG [NUM_SLOTS][NUM_ANT] = '{
    '{1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b1, 1'b0, 1'b1, 1'b0},
    '{1'b1, 1'b0, 1'b0, 1'b1},
    '{1'b1, 1'b1, 1'b0, 1'b0}
  };

  // Handoff of a full block from the collector to the row generator
  typedef struct packed {
    logic       load;
    code_mode_t mode;
  } blk_ctrl_t;

  function automatic logic is_two_ant(input code_mode_t mode);
    return (mode == MODE_ALAMOUTI) || (mode == MODE_ALAMOUTI_SWAP);
  endfunction

endpackage

FILE: rtl/stbc_if.sv
`timescale 1ns / 1ps

// Complex sample channel
interface stbc_sample_if #(
  parameter int W = 16
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] sample_re;
  logic signed [W-1:0] sample_im;

  modport source (output valid, output sample_re, output sample_im, input ready);
  modport sink   (input valid, input sample_re, input sample_im, output ready);
endinterface

// Code row channel: one symbol per antenna
interface stbc_row_if #(
  parameter int W = 16
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] ant0_re;
  logic signed [W-1:0] ant0_im;
  logic signed [W-1:0] ant1_re;
  logic signed [W-1:0] ant1_im;
  logic signed [W-1:0] ant2_re;
  logic signed [W-1:0] ant2_im;
  logic signed [W-1:0] ant3_re;
  logic signed [W-1:0] ant3_im;
  logic [2:0]          row_index;
  logic                block_last;

  modport source (
    output valid, input ready,
    output ant0_re, output ant0_im, output ant1_re, output ant1_im,
    output ant2_re, output ant2_im, output ant3_re, output ant3_im,
    output row_index, output block_last
  );
  modport sink (
    input valid, output ready,
    input ant0_re, input ant0_im, input ant1_re, input ant1_im,
    input ant2_re, input ant2_im, input ant3_re, input ant3_im,
    input row_index, input block_last
  );
endinterface

FILE: rtl/stbc_collect.sv
`timescale 1ns / 1ps

// Gathers samples into a code block and hands full blocks to the row generator
module stbc_collect #(
  parameter int W = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic signed [W-1:0]    in_re,
  input  logic signed [W-1:0]    in_im,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_wdata,
  input  logic                   gen_free,
  output stbc_pkg::blk_ctrl_t    blk_ctrl,
  output logic signed [W-1:0]    blk_re [stbc_pkg::NUM_SLOTS],
  output logic signed [W-1:0]    blk_im [stbc_pkg::NUM_SLOTS]
);
  import stbc_pkg::*;

  code_mode_t          code_mode;
  logic [1:0]          fill_count;
  logic signed [W-1:0] sbuf_re [BUF_DEPTH];
  logic signed [W-1:0] sbuf_im [BUF_DEPTH];
  logic                two_ant;
  logic                last_slot;
  logic                accept;

  assign two_ant   = is_two_ant(code_mode);
  assign last_slot = two_ant ? (fill_count == 2'd1) : (fill_count == 2'd3);
  // the completing sample stalls only while the generator still holds a block
  assign in_ready  = !last_slot || gen_free;
  assign accept    = in_valid && in_ready;

  // control: mode register and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      code_mode  <= MODE_ALAMOUTI;
      fill_count <= '0;
    end else if (cfg_we) begin
      code_mode  <= code_mode_t'(cfg_wdata);
      fill_count <= '0;
    end else if (accept) begin
      fill_count <= last_slot ? 2'd0 : fill_count + 2'd1;
    end
  end

  // sample buffer, one write port
  always_ff @(posedge clk) begin
    if (accept && !last_slot) begin
      sbuf_re[fill_count] <= in_re;
      sbuf_im[fill_count] <= in_im;
    end
  end

  // block view: the incoming sample completes the block
  assign blk_ctrl.load = accept && last_slot;
  assign blk_ctrl.mode = code_mode;

  assign blk_re[0] = sbuf_re[0];
  assign blk_im[0] = sbuf_im[0];
  assign blk_re[1] = two_ant ? in_re : sbuf_re[1];
  assign blk_im[1] = two_ant ? in_im : sbuf_im[1];
  assign blk_re[2] = sbuf_re[2];
  assign blk_im[2] = sbuf_im[2];
  assign blk_re[3] = in_re;
  assign blk_im[3] = in_im;

endmodule

FILE: rtl/stbc_rowgen.sv
`timescale 1ns / 1ps

// Holds one code block; rows leave an output register, one per cycle unless stalled
module stbc_rowgen #(
  parameter int W = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  stbc_pkg::blk_ctrl_t    blk_ctrl,
  input  logic signed [W-1:0]    blk_re [stbc_pkg::NUM_SLOTS],
  input  logic signed [W-1:0]    blk_im [stbc_pkg::NUM_SLOTS],
  output logic                   gen_free,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic signed [W-1:0]    ant_re [stbc_pkg::NUM_ANT],
  output logic signed [W-1:0]    ant_im [stbc_pkg::NUM_ANT],
  output logic [2:0]             row_index,
  output logic                   block_last
);
  import stbc_pkg::*;

  localparam logic signed [W-1:0] S_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] S_MIN = {1'b1, {(W-1){1'b0}}};

  logic signed [W-1:0] hold_re [NUM_SLOTS];
  logic signed [W-1:0] hold_im [NUM_SLOTS];
  code_mode_t          mode;
  logic                gen_valid;
  logic [2:0]          row;
  logic                two_ant;
  logic                last_row;
  logic                fire;
  logic                conj;
  logic [1:0]          trow;
  logic signed [W-1:0] lane_re [NUM_ANT];
  logic signed [W-1:0] lane_im [NUM_ANT];

  function automatic logic signed [W-1:0] neg_sat(input logic signed [W-1:0] x);
    return (x == S_MIN) ? S_MAX : -x;
  endfunction

  assign two_ant  = is_two_ant(mode);
  assign last_row = two_ant ? (row == ROW_LAST_2ANT) : (row == ROW_LAST_4ANT);
  assign fire     = gen_valid && (!out_valid || out_ready);
  assign gen_free = !gen_valid || (fire && last_row);
  assign conj     = two_ant ? row[0] : row[2];
  assign trow     = two_ant ? {1'b0, row[0]} : row[1:0];

  // block register, loaded when the collector completes a block
  always_ff @(posedge clk) begin
    if (blk_ctrl.load && gen_free) begin
      hold_re <= blk_re;
      hold_im <= blk_im;
      mode    <= blk_ctrl.mode;
    end
  end

  // row sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      gen_valid <= 1'b0;
      row       <= '0;
    end else if (blk_ctrl.load && gen_free) begin
      gen_valid <= 1'b1;
      row       <= '0;
    end else if (fire) begin
      gen_valid <= !last_row;
      row       <= last_row ? 3'd0 : row + 3'd1;
    end
  end

  // per-antenna symbol: sample slot, optional negation and conjugation
  for (genvar a = 0; a < NUM_ANT; a++) begin : g_lane
    logic                neg;
    logic                en;
    logic [1:0]          idx;
    logic signed [W-1:0] s_re;
    logic signed [W-1:0] s_im;

    assign idx  = ROW_IDX[trow][a];
    // swapped Alamouti moves the minus sign to antenna 1 on the second row
    assign neg  = ROW_NEG[trow][a] ^ ((mode == MODE_ALAMOUTI_SWAP) && row[0] && (a < 2));
    assign en   = (a < 2) || ((a == 2) && !two_ant) || (mode == MODE_OSTBC4);
    assign s_re = hold_re[idx];
    assign s_im = hold_im[idx];

    always_comb begin
      lane_re[a] = '0;
      lane_im[a] = '0;
      if (en) begin
        lane_re[a] = neg ? neg_sat(s_re) : s_re;
        lane_im[a] = (neg ^ conj) ? neg_sat(s_im) : s_im;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      ant_re     <= lane_re;
      ant_im     <= lane_im;
      row_index  <= row;
      block_last <= last_row;
    end
  end

endmodule

FILE: rtl/stbc_encoder_multi_mode.sv
`timescale 1ns / 1ps
// The first row of a block passes the block register and then the output register after
// the transfer of its last sample. The collector takes one sample transfer per cycle
// unless the completing sample waits for the row generator; rows leave one per cycle from
// the output register while ready is high, 8 rows per 4 samples in the 3/4-antenna modes.
// Reset (rst, synchronous): mode Alamouti, fill count cleared, no rows pending.
module stbc_encoder_multi_mode #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic          clk,
  input  logic          rst,
  stbc_sample_if.sink   sample_in,
  stbc_row_if.source    row_out,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_wdata
);
  import stbc_pkg::*;

  blk_ctrl_t                     blk_ctrl;
  logic                          gen_free;
  logic signed [SAMPLE_WIDTH-1:0] blk_re [NUM_SLOTS];
  logic signed [SAMPLE_WIDTH-1:0] blk_im [NUM_SLOTS];
  logic signed [SAMPLE_WIDTH-1:0] ant_re [NUM_ANT];
  logic signed [SAMPLE_WIDTH-1:0] ant_im [NUM_ANT];

  stbc_collect #(.W(SAMPLE_WIDTH)) u_collect (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sample_in.valid),
    .in_ready  (sample_in.ready),
    .in_re     (sample_in.sample_re),
    .in_im     (sample_in.sample_im),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .gen_free  (gen_free),
    .blk_ctrl  (blk_ctrl),
    .blk_re    (blk_re),
    .blk_im    (blk_im)
  );

  stbc_rowgen #(.W(SAMPLE_WIDTH)) u_rowgen (
    .clk        (clk),
    .rst        (rst),
    .blk_ctrl   (blk_ctrl),
    .blk_re     (blk_re),
    .blk_im     (blk_im),
    .gen_free   (gen_free),
    .out_valid  (row_out.valid),
    .out_ready  (row_out.ready),
    .ant_re     (ant_re),
    .ant_im     (ant_im),
    .row_index  (row_out.row_index),
    .block_last (row_out.block_last)
  );

  assign row_out.ant0_re = ant_re[0];
  assign row_out.ant0_im = ant_im[0];
  assign row_out.ant1_re = ant_re[1];
  assign row_out.ant1_im = ant_im[1];
  assign row_out.ant2_re = ant_re[2];
  assign row_out.ant2_im = ant_im[2];
  assign row_out.ant3_re = ant_re[3];
  assign row_out.ant3_im = ant_im[3];

endmodule

FILE: rtl/stbc_checker.sv
`timescale 1ns / 1ps

// Port-level checks on the row output
module stbc_checker #(
  parameter int W = 16
) (
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_ready,
  input logic signed [W-1:0] ant2_re,
  input logic signed [W-1:0] ant2_im,
  input logic signed [W-1:0] ant3_re,
  input logic signed [W-1:0] ant3_im,
  input logic [2:0]          row_index,
  input logic                block_last
);

  // a row waiting for transfer stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("row withdrawn before transfer");

  // a block ends only on row 1 or row 7
  a_last_row: assert property (@(posedge clk) disable iff (rst)
    out_valid && block_last |-> (row_index == 3'd1) || (row_index == 3'd7))
    else $error("block_last on wrong row");

  // a block never ends on its first row
  a_first_row: assert property (@(posedge clk) disable iff (rst)
    out_valid && (row_index == 3'd0) |-> !block_last)
    else $error("block_last on row 0");

  // two-antenna blocks drive antennas 2 and 3 to zero, checked on their last row
  a_unused_ant: assert property (@(posedge clk) disable iff (rst)
    out_valid && block_last && (row_index == 3'd1) |->
      (ant2_re == '0) && (ant2_im == '0) && (ant3_re == '0) && (ant3_im == '0))
    else $error("unused antenna not zero");

  // nothing is offered right after reset
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("row valid after reset");

endmodule

bind stbc_encoder_multi_mode stbc_checker #(.W(SAMPLE_WIDTH)) u_stbc_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (row_out.valid),
  .out_ready  (row_out.ready),
  .ant2_re    (row_out.ant2_re),
  .ant2_im    (row_out.ant2_im),
  .ant3_re    (row_out.ant3_re),
  .ant3_im    (row_out.ant3_im),
  .row_index  (row_out.row_index),
  .block_last (row_out.block_last)
);

FILE: verif/stbc_encoder_multi_mode_tb.sv
`timescale 1ns / 1ps

module stbc_encoder_multi_mode_tb;
  import stbc_pkg::*;

  localparam int W = 16;

  // Rows 0..3 of the four-antenna code: sign * (slot + 1)
  localparam int OSTBC_ROW [4][4] = '{
    '{ 1,  2,  3,  4},
    '{-2,  1, -4,  3},
    '{-3,  4,  1, -2},
    '{-4, -3,  2,  1}
  };

  typedef struct packed {
    logic [W-1:0] re;
    logic [W-1:0] im;
  } sample_t;

  typedef struct packed {
    logic [3:0][W-1:0] re;
    logic [3:0][W-1:0] im;
    logic [2:0]        row_index;
    logic              block_last;
  } code_row_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [1:0] cfg_wdata;

  stbc_sample_if #(.W(W)) sample_ch ();
  stbc_row_if    #(.W(W)) row_ch ();

  stbc_encoder_multi_mode #(.SAMPLE_WIDTH(W)) dut (
    .clk       (clk),
    .rst       (rst),
    .sample_in (sample_ch),
    .row_out   (row_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Stimulus and expectations
  sample_t   sample_queue[$];
  code_row_t expected_rows[$];
  int        errors = 0;
  bit        no_gaps = 0;
  bit        no_stall = 0;

  // Encoder copy used for prediction
  code_mode_t       enc_mode;
  int               enc_fill;
  logic signed [W-1:0] blk_re [4];
  logic signed [W-1:0] blk_im [4];

  function automatic logic signed [W-1:0] neg_sat(input logic signed [W-1:0] v);
    if (v == {1'b1, {(W-1){1'b0}}}) return {1'b0, {(W-1){1'b1}}};
    return -v;
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 65) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return {1'b1, {(W-1){1'b0}}};
      1: return {1'b0, {(W-1){1'b1}}};
      2: return ($urandom_range(0, 1) != 0) ? '0 : '1;
      default: return W'($urandom);
    endcase
  endfunction

  task automatic put_sym(inout code_row_t row, input int ant, input int slot,
                         input bit neg, input bit cj);
    logic signed [W-1:0] sre, sim;
    sre = blk_re[slot];
    sim = blk_im[slot];
    row.re[ant] = neg ? neg_sat(sre) : sre;
    row.im[ant] = (neg ^ cj) ? neg_sat(sim) : sim;
  endtask

  // Buffer one sample; on a full block queue all of its code rows
  task automatic encode_sample(input sample_t s);
    int blk_len, nrows, nant, e;
    code_row_t row;
    bit two_ant;
    two_ant = (enc_mode == MODE_ALAMOUTI) || (enc_mode == MODE_ALAMOUTI_SWAP);
    blk_re[enc_fill] = s.re;
    blk_im[enc_fill] = s.im;
    enc_fill++;
    blk_len = two_ant ? 2 : 4;
    if (enc_fill < blk_len) return;
    enc_fill = 0;
    nrows = two_ant ? 2 : 8;
    nant = (enc_mode == MODE_OSTBC3) ? 3 : 4;
    for (int r = 0; r < nrows; r++) begin
      row = '0;
      case (enc_mode)
        MODE_ALAMOUTI: begin
          if (r == 0) begin
            put_sym(row, 0, 0, 1'b0, 1'b0);
            put_sym(row, 1, 1, 1'b0, 1'b0);
          end else begin
            put_sym(row, 0, 1, 1'b1, 1'b1);
            put_sym(row, 1, 0, 1'b0, 1'b1);
          end
        end
        MODE_ALAMOUTI_SWAP: begin
          if (r == 0) begin
            put_sym(row, 0, 0, 1'b0, 1'b0);
            put_sym(row, 1, 1, 1'b0, 1'b0);
          end else begin
            put_sym(row, 0, 1, 1'b0, 1'b1);
            put_sym(row, 1, 0, 1'b1, 1'b1);
          end
        end
        default: begin
          for (int a = 0; a < nant; a++) begin
            e = OSTBC_ROW[r % 4][a];
            put_sym(row, a, (e < 0 ? -e : e) - 1, e < 0, r >= 4);
          end
        end
      endcase
      row.row_index = 3'(r);
      row.block_last = (r == nrows - 1);
      expected_rows.push_back(row);
    end
  endtask

  // Driver: presents queued samples, predicts on each transfer
  sample_t cur_sample;
  int      send_gap;

  always @(posedge clk) begin
    bit nxt_valid;
    if (rst) begin
      sample_ch.valid <= 1'b0;
      send_gap = 0;
      enc_mode = MODE_ALAMOUTI;
      enc_fill = 0;
    end else begin
      if (cfg_we) begin
        enc_mode = code_mode_t'(cfg_wdata);
        enc_fill = 0;
      end
      if (sample_ch.valid && sample_ch.ready) encode_sample(cur_sample);
      nxt_valid = sample_ch.valid && !sample_ch.ready;
      if (!nxt_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (sample_queue.size() > 0) begin
          cur_sample = sample_queue.pop_front();
          sample_ch.sample_re <= cur_sample.re;
          sample_ch.sample_im <= cur_sample.im;
          nxt_valid = 1'b1;
          send_gap = no_gaps ? 0 : pick_gap();
        end
      end
      sample_ch.valid <= nxt_valid;
    end
  end

  task automatic cmp_field(input string name, input int row, input logic [W-1:0] e,
                           input logic [W-1:0] a);
    if (e !== a) begin
      $display("%0t: row %0d %s mismatch, expected %0d actual %0d",
               $time, row, name, $signed(e), $signed(a));
      errors++;
    end
  endtask

  // Monitor: checks each row transfer, throttles ready
  int rows_seen;
  int stall_left;
  int long_hold;

  always @(posedge clk) begin
    code_row_t exp_row;
    bit rdy;
    if (rst) begin
      row_ch.ready <= 1'b0;
      rows_seen = 0;
      stall_left = 0;
      long_hold = 0;
    end else begin
      if (row_ch.valid && row_ch.ready) begin
        if (expected_rows.size() == 0) begin
          $display("%0t: unexpected row, index %0d", $time, row_ch.row_index);
          errors++;
        end else begin
          exp_row = expected_rows.pop_front();
          cmp_field("ant0_re", rows_seen, exp_row.re[0], row_ch.ant0_re);
          cmp_field("ant0_im", rows_seen, exp_row.im[0], row_ch.ant0_im);
          cmp_field("ant1_re", rows_seen, exp_row.re[1], row_ch.ant1_re);
          cmp_field("ant1_im", rows_seen, exp_row.im[1], row_ch.ant1_im);
          cmp_field("ant2_re", rows_seen, exp_row.re[2], row_ch.ant2_re);
          cmp_field("ant2_im", rows_seen, exp_row.im[2], row_ch.ant2_im);
          cmp_field("ant3_re", rows_seen, exp_row.re[3], row_ch.ant3_re);
          cmp_field("ant3_im", rows_seen, exp_row.im[3], row_ch.ant3_im);
          cmp_field("row_index", rows_seen, W'(exp_row.row_index), W'(row_ch.row_index));
          cmp_field("block_last", rows_seen, W'(exp_row.block_last), W'(row_ch.block_last));
        end
        rows_seen++;
        // long back-pressure so the block fills and stalls its input
        if (rows_seen == 60 || rows_seen == 1000) long_hold = 150;
      end
      if (long_hold > 0) begin
        long_hold--;
        rdy = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
        stall_left = no_stall ? 0 : pick_gap();
      end
      row_ch.ready <= rdy;
    end
  end

  // Wait until no sample is pending and every row has been checked
  task automatic wait_idle();
    do @(negedge clk);
    while (sample_queue.size() != 0 || sample_ch.valid || expected_rows.size() != 0);
  endtask

  task automatic set_mode(input code_mode_t m);
    wait_idle();
    repeat (8) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic push_sample(input logic [W-1:0] re, input logic [W-1:0] im);
    sample_t s;
    s.re = re;
    s.im = im;
    sample_queue.push_back(s);
  endtask

  initial begin
    logic [W-1:0] ext [5];
    code_mode_t m;
    int sent, blk_len, nblk;
    ext[0] = {1'b1, {(W-1){1'b0}}};
    ext[1] = {1'b0, {(W-1){1'b1}}};
    ext[2] = '0;
    ext[3] = '1;
    ext[4] = W'(1);
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    sample_ch.valid = 1'b0;
    sample_ch.sample_re = '0;
    sample_ch.sample_im = '0;
    row_ch.ready = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: field extremes in every mode, saturating negation included
    for (int k = 0; k < 4; k++) begin
      set_mode(code_mode_t'(k));
      push_sample(ext[0], ext[0]);
      for (int i = 1; i < ((k < 2) ? 4 : 8); i++)
        push_sample(ext[(i + k) % 5], ext[(i + k + 2) % 5]);
    end
    // Partial block, then a mode change discards it
    push_sample(ext[1], ext[0]);
    set_mode(MODE_ALAMOUTI);
    push_sample(ext[0], ext[1]);
    push_sample(ext[1], ext[0]);

    // Random phases, mostly whole blocks, some left partial at the mode change
    sent = 0;
    for (int ph = 0; sent < 420; ph++) begin
      m = (ph < 4) ? code_mode_t'(3 - ph) : code_mode_t'($urandom_range(0, 3));
      set_mode(m);
      no_gaps = ($urandom_range(0, 3) == 0);
      no_stall = no_gaps;
      blk_len = (m == MODE_ALAMOUTI || m == MODE_ALAMOUTI_SWAP) ? 2 : 4;
      nblk = $urandom_range(40, 60) / blk_len;
      for (int i = 0; i < nblk * blk_len; i++) push_sample(pick_value(), pick_value());
      sent += nblk * blk_len;
      if ($urandom_range(0, 1) != 0) begin
        for (int i = $urandom_range(1, blk_len - 1); i > 0; i--) begin
          push_sample(pick_value(), pick_value());
          sent++;
        end
      end
    end

    wait_idle();
    no_gaps = 0;
    no_stall = 0;
    repeat (20) @(posedge clk);
    if (errors == 0 && expected_rows.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

FILE: stbc_encoder_multi_mode.f
rtl/stbc_pkg.sv
rtl/stbc_if.sv
rtl/stbc_collect.sv
rtl/stbc_rowgen.sv
rtl/stbc_encoder_multi_mode.sv
rtl/stbc_checker.sv
verif/stbc_encoder_multi_mode_tb.sv
